### rtl/double_sha512_nonce_search_top_defines.svh
// Assertion macros shared by the nonce search RTL.
`ifndef DOUBLE_SHA512_NONCE_SEARCH_TOP_DEFINES_SVH
`define DOUBLE_SHA512_NONCE_SEARCH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DSN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DSN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DSN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DSN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/dsn_pkg.sv
// Package with SHA-512 constants, types and round functions.
package dsn_pkg;
    localparam int unsigned RoundCount = 80;
    typedef logic [63:0] t_word;
    typedef logic [6:0]  t_round;

    localparam t_word Iv [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam t_word PadBit    = 64'h8000000000000000;
    localparam t_word LenFirst  = 64'd576;
    localparam t_word LenSecond = 64'd512;

    // Control from the sequencer to the round engine.
    typedef struct packed {
        logic   start;
        logic   pass;
    } t_eng_ctl;

    typedef struct packed {
        logic   busy;
        logic   done;
    } t_eng_sts;

    function automatic t_word ror(input t_word x, input int unsigned n);
        ror = (x >> n) | (x << (64 - n));
    endfunction

    function automatic t_word round_k(input t_round r);
        case (r)
            7'd0:  round_k = 64'h428a2f98d728ae22; 7'd1:  round_k = 64'h7137449123ef65cd;
            7'd2:  round_k = 64'hb5c0fbcfec4d3b2f; 7'd3:  round_k = 64'he9b5dba58189dbbc;
            7'd4:  round_k = 64'h3956c25bf348b538; 7'd5:  round_k = 64'h59f111f1b605d019;
            7'd6:  round_k = 64'h923f82a4af194f9b; 7'd7:  round_k = 64'hab1c5ed5da6d8118;
            7'd8:  round_k = 64'hd807aa98a3030242; 7'd9:  round_k = 64'h12835b0145706fbe;
            7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
            7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
            7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
            7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
            7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
            7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
            7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
            7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
            7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
            7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
            7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
            7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
            7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
            7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
            7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
            7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
            7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
            7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
            7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
            7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
            7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
            7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
            7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
            7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
            7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
            7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
            7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
            7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
            7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
            7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
            7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
            7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
            7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
            7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
            7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
            default: round_k = '0;
        endcase
    endfunction
endpackage

### rtl/dsn_round_engine.sv
// SHA-512 compression unit: one round per cycle over a 16-word shift window.
module dsn_round_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dsn_pkg::t_eng_ctl  i_ctl,
    input  dsn_pkg::t_word     i_nonce,
    input  dsn_pkg::t_word     i_ihash [8],
    output dsn_pkg::t_eng_sts  o_sts,
    output dsn_pkg::t_word     o_digest0
);
    import dsn_pkg::*;

    t_word  r_w [16];
    t_word  r_v [8];
    t_word  r_h [8];
    t_round r_round;
    logic   r_busy;
    logic   r_done;

    t_word  w_new, s0, s1, t1, t2;

    // Next schedule word from the window head, and the round terms t1 and t2.
    always_comb begin
        s0    = ror(r_w[1], 1) ^ ror(r_w[1], 8) ^ (r_w[1] >> 7);
        s1    = ror(r_w[14], 19) ^ ror(r_w[14], 61) ^ (r_w[14] >> 6);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        t1 = r_v[7] + (ror(r_v[4], 14) ^ ror(r_v[4], 18) ^ ror(r_v[4], 41))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_round) + r_w[0];
        t2 = (ror(r_v[0], 28) ^ ror(r_v[0], 34) ^ ror(r_v[0], 39))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                for (int k = 0; k < 8; k++) begin
                    r_v[k] <= Iv[k];
                    r_h[k] <= Iv[k];
                end
                // Load the padded message block for the selected pass.
                if (!i_ctl.pass) begin
                    r_w[0] <= i_nonce;
                    for (int k = 0; k < 8; k++) r_w[k+1] <= i_ihash[k];
                    r_w[9] <= PadBit;
                    for (int k = 10; k < 15; k++) r_w[k] <= '0;
                    r_w[15] <= LenFirst;
                end else begin
                    for (int k = 0; k < 8; k++) r_w[k] <= r_h[k];
                    r_w[8] <= PadBit;
                    for (int k = 9; k < 15; k++) r_w[k] <= '0;
                    r_w[15] <= LenSecond;
                end
            end else if (r_busy) begin
                for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
                r_w[15] <= w_new;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                if (r_round == t_round'(RoundCount - 1)) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_round <= '0;
                end else begin
                    r_round <= r_round + 7'd1;
                end
            end else if (r_done) begin
                // Fold the working variables into the chaining words.
                for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
            end
        end
    end

    // Digest is valid in the cycle after done, once folded.
    logic r_fold;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fold <= 1'b0;
        else          r_fold <= r_done;
    end

    assign o_sts.busy = r_busy | r_done;
    assign o_sts.done = r_fold;
    assign o_digest0  = r_h[0];

    `include "double_sha512_nonce_search_top_defines.svh"
    `DSN_ASSERT_IMPL(a_round_range, i_clk, i_rst_n, 1'b1, r_round < t_round'(RoundCount))
    `DSN_ASSERT_NEXT(a_done_ends, i_clk, i_rst_n, r_done, !r_busy)
    `DSN_ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_ctl.start, !r_busy && !r_done)
endmodule

### rtl/double_sha512_nonce_search_top.sv
// Top level: word loader, nonce sequencer and result register around the round engine.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready     tdata[66:0] = word_index[2:0], hash_word[66:3]
//  m_axis    out  m_axis_tvalid/tready     tdata[127:0] = found_nonce, trial_value
//  cfg       in   i_cfg_valid/o_cfg_ready  i_cfg_data = target
//
// Items with word index 0..6 are stored. Index 7 is stored as well and
// starts a search: each nonce takes two passes (block load, 80 rounds,
// fold, latch) through the single round unit. Input ready stays low
// from search start until the result has been taken. Synchronous
// active-low reset; the result register holds while the output stalls.
module double_sha512_nonce_search_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,   // word_index[2:0], hash_word[66:3], zero fill
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // found_nonce[63:0], trial_value[127:64]
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [63:0]   i_cfg_data
);
    import dsn_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_P1, S_W1, S_P2, S_W2, S_OUT} t_state;

    t_state   r_state;
    t_word    r_ihash [8];
    t_word    r_nonce;
    t_word    r_target;
    t_word    r_trial;
    t_eng_ctl w_ctl;
    t_eng_sts w_sts;
    t_word    w_dig;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_trial, r_nonce};

    assign w_ctl.start = (r_state == S_P1) || (r_state == S_P2);
    assign w_ctl.pass  = (r_state == S_P2);

    dsn_round_engine u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_nonce(r_nonce),
        .i_ihash(r_ihash), .o_sts(w_sts), .o_digest0(w_dig)
    );

    // Hash words need no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            r_ihash[s_axis_tdata[2:0]] <= s_axis_tdata[66:3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_target <= '1;
            r_nonce  <= '0;
            r_trial  <= '0;
        end else begin
            if (i_cfg_valid) r_target <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tdata[2:0] == 3'd7) begin
                        r_nonce <= 64'd1;
                        r_state <= S_P1;
                    end
                end
                S_P1: r_state <= S_W1;
                S_W1: if (w_sts.done) r_state <= S_P2;
                S_P2: r_state <= S_W2;
                S_W2: begin
                    if (w_sts.done) begin
                        r_trial <= w_dig;
                        if (w_dig <= r_target) begin
                            r_state <= S_OUT;
                        end else begin
                            r_nonce <= r_nonce + 64'd1;
                            r_state <= S_P1;
                        end
                    end
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "double_sha512_nonce_search_top_defines.svh"
    `DSN_ASSERT_IMPL(a_out_meets, i_clk, i_rst_n, m_axis_tvalid, r_trial <= r_target)
    `DSN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(r_nonce))
    `DSN_ASSERT_IMPL(a_no_start_busy, i_clk, i_rst_n, w_ctl.start, !w_sts.busy)
endmodule
